[rtl/c8_pkg.sv]
// Shared constants, types and helper functions for the CHIP-8 instruction core.
package c8_pkg;

    localparam int STACK_DEPTH = 16;    // 2 .. 64
    localparam int MEM_BYTES   = 4096;  // power of two, 512 .. 4096
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int SI_W        = $clog2(STACK_DEPTH);
    localparam int FONT_BYTES  = 80;

    localparam logic [11:0] PC_RESET = 12'h200;
    localparam logic [11:0] ADDR_MAX = 12'hFFF;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OP_RET = 16'h00EE;

    // 8xyN sub-ops
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Ex and Fx low bytes
    localparam logic [7:0] KEY_EQ    = 8'h9E;
    localparam logic [7:0] KEY_NE    = 8'hA1;
    localparam logic [7:0] FX_GETDT  = 8'h07;
    localparam logic [7:0] FX_SETDT  = 8'h15;
    localparam logic [7:0] FX_SETST  = 8'h18;
    localparam logic [7:0] FX_ADDI   = 8'h1E;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    // multi-cycle memory sequences
    localparam logic [1:0] SEQ_NONE  = 2'd0;
    localparam logic [1:0] SEQ_BCD   = 2'd1;
    localparam logic [1:0] SEQ_STORE = 2'd2;
    localparam logic [1:0] SEQ_LOAD  = 2'd3;

    typedef struct packed {
        logic [11:0] npc;
        logic        rf_we;
        logic [7:0]  rf_wdata;
        logic        vf_we;
        logic        vf_data;
        logic        index_we;
        logic [11:0] index_next;
        logic        delay_we;
        logic        sound_we;
        logic        push;
        logic        pop;
        logic        serr;
        logic        unsup;
        logic [1:0]  seq;
    } exec_t;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    // decimal digit of v: sel 0 = hundreds, 1 = tens, 2 = ones
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  hund;
        logic [7:0]  rem;
        logic [13:0] prod;
        logic [3:0]  tens;
        logic [7:0]  ones;
        hund = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        rem  = v - 8'(hund * 7'd100);
        prod = 14'(rem[6:0] * 7'd103);  // rem < 100: x*103 >> 10 == x / 10
        tens = prod[13:10];
        ones = rem - 8'(tens * 4'd10);
        unique case (sel)
            2'd0:    bcd_digit = {6'd0, hund};
            2'd1:    bcd_digit = {4'd0, tens};
            default: bcd_digit = ones;
        endcase
    endfunction

endpackage

[rtl/c8_ram.sv]
// Generic single-port synchronous RAM, registered read data.
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[addr] <= wdata;
        end
        rdata_reg <= store_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/c8_exec.sv]
// Instruction decode and execute: next PC, register and index updates, flags.
module c8_exec (
    input  logic [15:0]              op,
    input  logic [7:0]               vx,
    input  logic [7:0]               vy,
    input  logic [7:0]               v0,
    input  logic [7:0]               key,
    input  logic [7:0]               rnd,
    input  logic [7:0]               delay,
    input  logic [11:0]              index,
    input  logic [11:0]              pc,
    input  logic [c8_pkg::SP_W-1:0]  level,
    input  logic [11:0]              stack_top,
    output c8_pkg::exec_t            ex
);
    import c8_pkg::*;

    logic [11:0] seq_pc;
    logic [11:0] skip_pc;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [8:0]  add9;
    logic [12:0] idx13;

    always_comb
    begin
        seq_pc  = pc + 12'd2;
        skip_pc = pc + 12'd4;
        nn      = op[7:0];
        nnn     = op[11:0];
        add9    = {1'b0, vx} + {1'b0, vy};
        idx13   = {1'b0, index} + {5'd0, vx};

        ex            = '0;
        ex.npc        = seq_pc;
        ex.index_next = index;
        ex.seq        = SEQ_NONE;

        unique case (op[15:12])
            OP_SYS:
            begin
                if (op == OP_RET)
                begin
                    if (level == '0)
                    begin
                        ex.serr = 1'b1;
                    end
                    else
                    begin
                        ex.pop = 1'b1;
                        ex.npc = stack_top;
                    end
                end
                else
                begin
                    ex.unsup = 1'b1;
                end
            end
            OP_JP:   ex.npc = nnn;
            OP_CALL:
            begin
                if (level >= SP_W'(STACK_DEPTH))
                begin
                    ex.serr = 1'b1;
                end
                else
                begin
                    ex.push = 1'b1;
                    ex.npc  = nnn;
                end
            end
            OP_SEI:  if (vx == nn) ex.npc = skip_pc;
            OP_SNEI: if (vx != nn) ex.npc = skip_pc;
            OP_SER:  if (vx == vy) ex.npc = skip_pc;
            OP_LDI:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = nn;
            end
            OP_ADDI:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = vx + nn;
            end
            OP_ALU:
            begin
                ex.rf_we = 1'b1;
                unique case (op[3:0])
                    ALU_MOV: ex.rf_wdata = vy;
                    ALU_OR:  ex.rf_wdata = vx | vy;
                    ALU_AND: ex.rf_wdata = vx & vy;
                    ALU_XOR: ex.rf_wdata = vx ^ vy;
                    ALU_ADD:
                    begin
                        ex.rf_wdata = add9[7:0];
                        ex.vf_we    = 1'b1;
                        ex.vf_data  = add9[8];
                    end
                    ALU_SUB:
                    begin
                        ex.rf_wdata = vx - vy;
                        ex.vf_we    = 1'b1;
                        ex.vf_data  = (vx >= vy);
                    end
                    ALU_SHR:
                    begin
                        ex.rf_wdata = {1'b0, vx[7:1]};
                        ex.vf_we    = 1'b1;
                        ex.vf_data  = vx[0];
                    end
                    ALU_SUBN:
                    begin
                        ex.rf_wdata = vy - vx;
                        ex.vf_we    = 1'b1;
                        ex.vf_data  = (vy >= vx);
                    end
                    ALU_SHL:
                    begin
                        ex.rf_wdata = {vx[6:0], 1'b0};
                        ex.vf_we    = 1'b1;
                        ex.vf_data  = vx[7];
                    end
                    default:
                    begin
                        ex.rf_we = 1'b0;
                        ex.unsup = 1'b1;
                    end
                endcase
            end
            OP_SNER:  if (vx != vy) ex.npc = skip_pc;
            OP_LDIDX:
            begin
                ex.index_we   = 1'b1;
                ex.index_next = nnn;
            end
            OP_JPV0:  ex.npc = nnn + {4'd0, v0};
            OP_RND:
            begin
                ex.rf_we    = 1'b1;
                ex.rf_wdata = rnd & nn;
            end
            OP_DRW:   ex.unsup = 1'b1;
            OP_KEY:
            begin
                if (nn == KEY_EQ)
                begin
                    if (key == vx) ex.npc = skip_pc;
                end
                else if (nn == KEY_NE)
                begin
                    if (key != vx) ex.npc = skip_pc;
                end
                else
                begin
                    ex.unsup = 1'b1;
                end
            end
            default:  // OP_MISC
            begin
                unique case (nn)
                    FX_GETDT:
                    begin
                        ex.rf_we    = 1'b1;
                        ex.rf_wdata = delay;
                    end
                    FX_SETDT: ex.delay_we = 1'b1;
                    FX_SETST: ex.sound_we = 1'b1;
                    FX_ADDI:
                    begin
                        ex.index_we   = 1'b1;
                        ex.index_next = idx13[11:0];
                        ex.vf_we      = 1'b1;
                        ex.vf_data    = idx13[12];
                    end
                    FX_BCD:   ex.seq = SEQ_BCD;
                    FX_STORE: ex.seq = SEQ_STORE;
                    FX_LOAD:  ex.seq = SEQ_LOAD;
                    default:  ex.unsup = 1'b1;
                endcase
            end
        endcase
    end

endmodule

[rtl/chip8_instruction_core.sv]
// CHIP-8 instruction core top level: sequencer, state registers and memories.
//
// A request is taken when start is high and busy is low. func = 0 writes
// load_data to memory at load_address; func = 1 fetches the big-endian
// opcode at the program counter and executes it. Every request yields one
// result, shown for exactly one cycle with done high; the receiver cannot
// stall it, so capture it when done is seen. After reset the core walks all
// MEM_BYTES (4096) addresses, loading the font into bytes 0..79, zeroing the
// rest of memory and the V registers; busy is high during that pass. A load
// goes from idle to done. A step has extra states for ops that write VF, for
// Fx33 and for Fx55/Fx65: memory and the V register file are single-port RAMs,
// so the two opcode bytes, VX, VY and V0 are each read in a state of their
// own, and register save/load moves each byte through a read and a write
// state. Each step goes strictly read then write, so no forwarding is needed.
// Draw, clear, wait-key, font address and 0NNN set unsupported and skip.
module chip8_instruction_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        func,
    input  logic [11:0] load_address,
    input  logic [7:0]  load_data,
    input  logic [7:0]  key_code,
    input  logic [7:0]  random_byte,
    output logic [11:0] next_pc,
    output logic [11:0] index_value,
    output logic [15:0] executed_opcode,
    output logic        stack_error,
    output logic        unsupported,
    output logic        sound_on
);
    import c8_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_OPH   = 4'd2;
    localparam logic [3:0] S_OPL   = 4'd3;
    localparam logic [3:0] S_VX    = 4'd4;
    localparam logic [3:0] S_VY    = 4'd5;
    localparam logic [3:0] S_V0    = 4'd6;
    localparam logic [3:0] S_EXEC  = 4'd7;
    localparam logic [3:0] S_FLAG  = 4'd8;
    localparam logic [3:0] S_BCD   = 4'd9;
    localparam logic [3:0] S_STRD  = 4'd10;
    localparam logic [3:0] S_STWR  = 4'd11;
    localparam logic [3:0] S_LDRD  = 4'd12;
    localparam logic [3:0] S_LDWR  = 4'd13;
    localparam logic [3:0] S_DONE  = 4'd14;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic [3:0]        cnt_reg;
    logic [11:0]       pc_reg;
    logic [11:0]       index_reg;
    logic [SP_W-1:0]   level_reg;
    logic [7:0]        delay_reg;
    logic [7:0]        sound_reg;

    // payload
    logic [7:0]        op_hi_reg;
    logic [15:0]       op_reg;
    logic [15:0]       op_out_reg;
    logic [7:0]        vx_reg, vy_reg, v0_reg;
    logic [7:0]        key_reg, rnd_reg;
    logic              serr_reg, unsup_reg;
    logic              vf_reg;
    logic [11:0]       stack_reg [STACK_DEPTH];

    // memory ports
    logic              mem_we;
    logic [11:0]       mem_addr12;
    logic [7:0]        mem_wdata, mem_rdata;
    logic              rf_we;
    logic [3:0]        rf_addr;
    logic [7:0]        rf_wdata, rf_rdata;

    logic              accept;
    logic [11:0]       seq_addr;
    logic [SP_W-1:0]   level_m1;
    logic [11:0]       stack_top;
    exec_t             ex;

    assign accept    = start && (state_reg == S_IDLE);
    assign seq_addr  = index_reg + {8'd0, cnt_reg};
    assign level_m1  = level_reg - SP_W'(1);
    assign stack_top = stack_reg[level_m1[SI_W-1:0]];

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr12[MEM_AW-1:0]),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    c8_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .clk   (clk),
        .we    (rf_we),
        .addr  (rf_addr),
        .wdata (rf_wdata),
        .rdata (rf_rdata)
    );

    c8_exec u_exec (
        .op        (op_reg),
        .vx        (vx_reg),
        .vy        (vy_reg),
        .v0        (v0_reg),
        .key       (key_reg),
        .rnd       (rnd_reg),
        .delay     (delay_reg),
        .index     (index_reg),
        .pc        (pc_reg),
        .level     (level_reg),
        .stack_top (stack_top),
        .ex        (ex)
    );

    // port steering for both RAMs
    always_comb
    begin
        mem_we     = 1'b0;
        mem_addr12 = pc_reg;
        mem_wdata  = 8'd0;
        rf_we      = 1'b0;
        rf_addr    = 4'd0;
        rf_wdata   = 8'd0;
        unique case (state_reg)
            S_CLR:
            begin
                // font pass; the V registers are also zeroed, addressed by the low counter bits
                mem_we     = 1'b1;
                mem_addr12 = 12'(clr_cnt_reg);
                mem_wdata  = (clr_cnt_reg < MEM_AW'(FONT_BYTES)) ? FONT[clr_cnt_reg[6:0]] : 8'd0;
                rf_we      = 1'b1;
                rf_addr    = clr_cnt_reg[3:0];
            end
            S_IDLE:
            begin
                if (accept && !func)
                begin
                    mem_we     = 1'b1;
                    mem_addr12 = load_address;
                    mem_wdata  = load_data;
                end
            end
            S_OPH:  mem_addr12 = pc_reg + 12'd1;
            S_OPL:  rf_addr = op_hi_reg[3:0];
            S_VX:   rf_addr = op_reg[7:4];
            S_VY:   rf_addr = 4'd0;
            S_EXEC:
            begin
                rf_addr  = op_reg[11:8];
                rf_we    = ex.rf_we;
                rf_wdata = ex.rf_wdata;
            end
            S_FLAG:
            begin
                rf_addr  = 4'hF;
                rf_we    = 1'b1;
                rf_wdata = {7'd0, vf_reg};
            end
            S_BCD:
            begin
                mem_we     = 1'b1;
                mem_addr12 = seq_addr;
                mem_wdata  = bcd_digit(vx_reg, cnt_reg[1:0]);
            end
            S_STRD: rf_addr = cnt_reg;
            S_STWR:
            begin
                mem_we     = 1'b1;
                mem_addr12 = seq_addr;
                mem_wdata  = rf_rdata;
            end
            S_LDRD: mem_addr12 = seq_addr;
            S_LDWR:
            begin
                rf_we    = 1'b1;
                rf_addr  = cnt_reg;
                rf_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLR:  if (clr_cnt_reg == MEM_AW'(MEM_BYTES - 1)) state_next = S_IDLE;
            S_IDLE: if (accept) state_next = func ? S_OPH : S_DONE;
            S_OPH:  state_next = S_OPL;
            S_OPL:  state_next = S_VX;
            S_VX:   state_next = S_VY;
            S_VY:   state_next = S_V0;
            S_V0:   state_next = S_EXEC;
            S_EXEC:
            begin
                if (ex.vf_we)
                    state_next = S_FLAG;
                else if (ex.seq == SEQ_BCD)
                    state_next = S_BCD;
                else if (ex.seq == SEQ_STORE)
                    state_next = S_STRD;
                else if (ex.seq == SEQ_LOAD)
                    state_next = S_LDRD;
                else
                    state_next = S_DONE;
            end
            S_FLAG: state_next = S_DONE;
            S_BCD:  if (cnt_reg == 4'd2) state_next = S_DONE;
            S_STRD: state_next = S_STWR;
            S_STWR: state_next = (cnt_reg == op_reg[11:8]) ? S_DONE : S_STRD;
            S_LDRD: state_next = S_LDWR;
            S_LDWR: state_next = (cnt_reg == op_reg[11:8]) ? S_DONE : S_LDRD;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            cnt_reg     <= 4'd0;
            pc_reg      <= PC_RESET;
            index_reg   <= 12'd0;
            level_reg   <= '0;
            delay_reg   <= 8'd0;
            sound_reg   <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLR)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            end
            if (state_reg == S_EXEC)
            begin
                cnt_reg <= 4'd0;
                pc_reg  <= ex.npc;
                if (ex.index_we) index_reg <= ex.index_next;
                if (ex.delay_we) delay_reg <= vx_reg;
                if (ex.sound_we) sound_reg <= vx_reg;
                if (ex.push)     level_reg <= level_reg + SP_W'(1);
                if (ex.pop)      level_reg <= level_m1;
            end
            if (state_reg == S_BCD || state_reg == S_STWR || state_reg == S_LDWR)
            begin
                cnt_reg <= cnt_reg + 4'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg    <= key_code;
            rnd_reg    <= random_byte;
            op_out_reg <= 16'd0;
            serr_reg   <= 1'b0;
            unsup_reg  <= 1'b0;
        end
        if (state_reg == S_OPH) op_hi_reg <= mem_rdata;
        if (state_reg == S_OPL) op_reg    <= {op_hi_reg, mem_rdata};
        if (state_reg == S_VX)  vx_reg    <= rf_rdata;
        if (state_reg == S_VY)  vy_reg    <= rf_rdata;
        if (state_reg == S_V0)  v0_reg    <= rf_rdata;
        if (state_reg == S_EXEC)
        begin
            op_out_reg <= op_reg;
            serr_reg   <= ex.serr;
            unsup_reg  <= ex.unsup;
            vf_reg     <= ex.vf_data;
            if (ex.push) stack_reg[level_reg[SI_W-1:0]] <= pc_reg + 12'd2;
        end
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = (state_reg == S_DONE);
    assign next_pc         = pc_reg;
    assign index_value     = index_reg;
    assign executed_opcode = op_out_reg;
    assign stack_error     = serr_reg;
    assign unsupported     = unsup_reg;
    assign sound_on        = (sound_reg != 8'd0);

endmodule

[tb/tb_chip8_instruction_core.sv]
// Self-checking testbench for the CHIP-8 instruction core.
`timescale 1ns / 1ps

module tb_chip8_instruction_core;
    import c8_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        func;
    logic [11:0] load_address;
    logic [7:0]  load_data;
    logic [7:0]  key_code;
    logic [7:0]  random_byte;
    logic [11:0] next_pc;
    logic [11:0] index_value;
    logic [15:0] executed_opcode;
    logic        stack_error;
    logic        unsupported;
    logic        sound_on;

    localparam bit FUNC_LOAD = 1'b0;
    localparam bit FUNC_STEP = 1'b1;

    // font glyphs preloaded at bytes 0..79
    localparam logic [7:0] GLYPHS [80] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef struct {
        logic [11:0] pc;
        logic [11:0] idx;
        logic [15:0] op;
        logic        serr;
        logic        unsup;
        logic        snd;
    } core_result_t;

    // Shadow copy of the core's machine state; each request is executed here
    // as it is accepted and its result queued for the strobe.
    class c8_scoreboard;
        logic [7:0]   mem [4096];
        logic [7:0]   v [16];
        logic [11:0]  pc;
        logic [11:0]  idx;
        logic [11:0]  ret_addr [STACK_DEPTH];
        int           depth;
        logic [7:0]   delay_t;
        logic [7:0]   sound_t;
        core_result_t pending_results [$];
        bit           failed;

        function new();
            foreach (mem[i]) mem[i] = (i < 80) ? GLYPHS[i] : 8'h00;
            foreach (v[i]) v[i] = 8'h00;
            pc = PC_RESET;
            idx = 12'h000;
            depth = 0;
            delay_t = 8'h00;
            sound_t = 8'h00;
            failed = 1'b0;
        endfunction

        function void note_request(bit f, logic [11:0] a, logic [7:0] d,
                                   logic [7:0] key, logic [7:0] rnd);
            core_result_t r;
            logic [15:0]  op;
            logic [3:0]   x, y, n;
            logic [7:0]   nn, vx, vy;
            logic [11:0]  nnn, seq, skip, npc;
            logic [8:0]   sum9;
            logic [12:0]  sum13;
            op = 16'h0000;
            r.serr = 1'b0;
            r.unsup = 1'b0;
            if (f == FUNC_LOAD) begin
                mem[a] = d;
            end
            else begin
                op = {mem[pc], mem[12'(pc + 12'd1)]};
                x = op[11:8];
                y = op[7:4];
                n = op[3:0];
                nn = op[7:0];
                nnn = op[11:0];
                vx = v[x];
                vy = v[y];
                seq = pc + 12'd2;
                skip = pc + 12'd4;
                npc = seq;
                case (op[15:12])
                    OP_SYS:
                        if (op == OP_RET) begin
                            if (depth == 0) r.serr = 1'b1;
                            else begin
                                depth--;
                                npc = ret_addr[depth];
                            end
                        end
                        else r.unsup = 1'b1;
                    OP_JP:    npc = nnn;
                    OP_CALL:
                        if (depth >= STACK_DEPTH) r.serr = 1'b1;
                        else begin
                            ret_addr[depth] = seq;
                            depth++;
                            npc = nnn;
                        end
                    OP_SEI:   if (vx == nn) npc = skip;
                    OP_SNEI:  if (vx != nn) npc = skip;
                    OP_SER:   if (vx == vy) npc = skip;
                    OP_LDI:   v[x] = nn;
                    OP_ADDI:  v[x] = vx + nn;
                    OP_ALU:
                        case (n)
                            ALU_MOV: v[x] = vy;
                            ALU_OR:  v[x] = vx | vy;
                            ALU_AND: v[x] = vx & vy;
                            ALU_XOR: v[x] = vx ^ vy;
                            ALU_ADD: begin
                                sum9 = vx + vy;
                                v[x] = sum9[7:0];
                                v[15] = {7'd0, sum9[8]};
                            end
                            ALU_SUB: begin
                                v[x] = vx - vy;
                                v[15] = {7'd0, vx >= vy};
                            end
                            ALU_SHR: begin
                                v[x] = vx >> 1;
                                v[15] = {7'd0, vx[0]};
                            end
                            ALU_SUBN: begin
                                v[x] = vy - vx;
                                v[15] = {7'd0, vy >= vx};
                            end
                            ALU_SHL: begin
                                v[x] = vx << 1;
                                v[15] = {7'd0, vx[7]};
                            end
                            default: r.unsup = 1'b1;
                        endcase
                    OP_SNER:  if (vx != vy) npc = skip;
                    OP_LDIDX: idx = nnn;
                    OP_JPV0:  npc = nnn + {4'd0, v[0]};
                    OP_RND:   v[x] = rnd & nn;
                    OP_DRW:   r.unsup = 1'b1;
                    OP_KEY:
                        if (nn == KEY_EQ) begin
                            if (key == vx) npc = skip;
                        end
                        else if (nn == KEY_NE) begin
                            if (key != vx) npc = skip;
                        end
                        else r.unsup = 1'b1;
                    default:
                        case (nn)
                            FX_GETDT: v[x] = delay_t;
                            FX_SETDT: delay_t = vx;
                            FX_SETST: sound_t = vx;
                            FX_ADDI: begin
                                sum13 = idx + vx;
                                idx = sum13[11:0];
                                v[15] = {7'd0, sum13[12]};
                            end
                            FX_BCD: begin
                                mem[idx] = vx / 100;
                                mem[12'(idx + 12'd1)] = (vx / 10) % 10;
                                mem[12'(idx + 12'd2)] = vx % 10;
                            end
                            FX_STORE:
                                for (int i = 0; i <= x; i++) mem[12'(idx + i)] = v[i];
                            FX_LOAD:
                                for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + i)];
                            default: r.unsup = 1'b1;
                        endcase
                endcase
                pc = npc;
            end
            r.pc = pc;
            r.idx = idx;
            r.op = op;
            r.snd = (sound_t != 8'h00);
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [11:0] pc_o, logic [11:0] idx_o, logic [15:0] op_o,
                                   logic serr_o, logic unsup_o, logic snd_o);
            core_result_t w;
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: pc=%h op=%h", pc_o, op_o);
                failed = 1'b1;
                return;
            end
            w = pending_results.pop_front();
            if (pc_o !== w.pc) begin
                $error("next_pc: expected %h, got %h", w.pc, pc_o);
                failed = 1'b1;
            end
            if (idx_o !== w.idx) begin
                $error("index_value: expected %h, got %h", w.idx, idx_o);
                failed = 1'b1;
            end
            if (op_o !== w.op) begin
                $error("executed_opcode: expected %h, got %h", w.op, op_o);
                failed = 1'b1;
            end
            if (serr_o !== w.serr) begin
                $error("stack_error: expected %b, got %b", w.serr, serr_o);
                failed = 1'b1;
            end
            if (unsup_o !== w.unsup) begin
                $error("unsupported: expected %b, got %b", w.unsup, unsup_o);
                failed = 1'b1;
            end
            if (snd_o !== w.snd) begin
                $error("sound_on: expected %b, got %b", w.snd, snd_o);
                failed = 1'b1;
            end
        endfunction
    endclass

    c8_scoreboard sb;
    int           requests_sent;
    int           idle_pct;

    chip8_instruction_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .done            (done),
        .func            (func),
        .load_address    (load_address),
        .load_data       (load_data),
        .key_code        (key_code),
        .random_byte     (random_byte),
        .next_pc         (next_pc),
        .index_value     (index_value),
        .executed_opcode (executed_opcode),
        .stack_error     (stack_error),
        .unsupported     (unsupported),
        .sound_on        (sound_on)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // results cannot be held off, so every strobe is checked on the edge it ends
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(next_pc, index_value, executed_opcode,
                            stack_error, unsupported, sound_on);
    end

    // Sender idles a random number of cycles between requests.
    task automatic idle_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // One request; start stays high until an edge with busy low takes it.
    // Called right after a rising edge.
    task automatic send(bit f, logic [11:0] a, logic [7:0] d, logic [7:0] key, logic [7:0] rnd);
        idle_gap();
        start        <= 1'b1;
        func         <= f;
        load_address <= a;
        load_data    <= d;
        key_code     <= key;
        random_byte  <= rnd;
        do @(posedge clk); while (busy);
        sb.note_request(f, a, d, key, rnd);
        requests_sent++;
    endtask

    // Plants an opcode at the current PC, then executes it.
    task automatic run_op(logic [15:0] op, logic [7:0] key, logic [7:0] rnd);
        logic [11:0] at;
        at = sb.pc;
        send(FUNC_LOAD, at, op[15:8], $urandom, $urandom);
        send(FUNC_LOAD, 12'(at + 12'd1), op[7:0], $urandom, $urandom);
        send(FUNC_STEP, $urandom, $urandom, key, rnd);
    endtask

    // Random opcode from every group; immediate compare operands often hit the
    // shadow register values so both skip outcomes occur.
    function automatic logic [15:0] pick_op();
        logic [3:0]  x, y;
        logic [7:0]  nn;
        logic [3:0]  alu_ops [9] = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD,
                                     ALU_SUB, ALU_SHR, ALU_SUBN, ALU_SHL};
        logic [7:0]  fx_ops [7] = '{FX_GETDT, FX_SETDT, FX_SETST, FX_ADDI,
                                    FX_BCD, FX_STORE, FX_LOAD};
        x  = $urandom;
        y  = $urandom;
        nn = $urandom;
        case ($urandom_range(19))
            0:  return ($urandom_range(3) == 0) ? {OP_SYS, 12'(nn)} : OP_RET;
            1:  return {OP_JP, 12'($urandom)};
            2:  return {OP_CALL, 12'($urandom)};
            3:  return {OP_SEI, x, $urandom_range(1) ? sb.v[x] : nn};
            4:  return {OP_SNEI, x, $urandom_range(1) ? sb.v[x] : nn};
            5:  return {OP_SER, x, y, 4'($urandom)};
            6:  return {OP_LDI, x, nn};
            7:  return {OP_ADDI, x, nn};
            8, 9:
                return {OP_ALU, x, y, ($urandom_range(7) == 0) ? 4'($urandom)
                                                              : alu_ops[$urandom_range(8)]};
            10: return {OP_SNER, x, y, 4'($urandom)};
            11: return {OP_LDIDX, 12'($urandom)};
            12: return {OP_JPV0, 12'($urandom)};
            13: return {OP_RND, x, nn};
            14: return {OP_DRW, x, nn};
            15: return {OP_KEY, x, ($urandom_range(4) == 0) ? nn
                                  : ($urandom_range(1) ? KEY_EQ : KEY_NE)};
            default:
                return {OP_MISC, x, ($urandom_range(6) == 0) ? nn
                                    : fx_ops[$urandom_range(6)]};
        endcase
    endfunction

    initial
    begin
        logic [15:0] op;
        logic [7:0]  key;
        sb = new();
        requests_sent = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_LOAD;
        load_address = 12'h000;
        load_data = 8'h00;
        key_code = 8'h00;
        random_byte = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-stack return, flag register as destination on add
        // and shift, index add of V0 at 0xFFF, unsupported clear, PC wrap
        // through 0xFFF into the font area
        run_op(OP_RET, 8'h00, 8'h00);
        run_op(16'h6FFF, 8'h00, 8'h00);
        run_op(16'h8FF4, 8'h00, 8'h00);
        run_op(16'hAFFF, 8'h00, 8'h00);
        run_op(16'hF01E, 8'hFF, 8'hFF);
        run_op(16'h00E0, 8'h00, 8'h00);
        run_op(16'h1FFF, 8'h00, 8'h00);
        run_op(16'h8FFE, 8'h00, 8'h00);

        while (requests_sent < 900)
        begin
            case ((requests_sent * 4) / 900)
                0:       idle_pct = 0;
                1:       idle_pct = 67;
                2:       idle_pct = 0;
                default: idle_pct = 28;
            endcase
            case ($urandom_range(59))
                0: begin
                    // call chain deep enough to overflow, then unwind past empty
                    repeat (STACK_DEPTH + 1) run_op({OP_CALL, 12'($urandom)}, 8'h00, 8'h00);
                    repeat (STACK_DEPTH + 2) run_op(OP_RET, 8'h00, 8'h00);
                end
                1, 2, 3:
                    send(FUNC_LOAD, $urandom, $urandom, $urandom, $urandom);
                4, 5, 6:
                    send(FUNC_STEP, $urandom, $urandom, $urandom, $urandom);
                default: begin
                    op  = pick_op();
                    key = $urandom_range(1) ? sb.v[op[11:8]] : 8'($urandom);
                    run_op(op, key, $urandom);
                end
            endcase
        end
        start <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (!sb.failed && sb.pending_results.size() == 0)
            $display("tb_chip8_instruction_core passed");
        else
            $display("tb_chip8_instruction_core failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_chip8_instruction_core failed");
        $finish;
    end

endmodule
